// File: hw/rtl/tic_pkg.sv
package tic_pkg;

  localparam int ADDR_W = 5;

  localparam logic [2:0] REG_COAST_ENABLE = 3'd0;
  localparam logic [2:0] REG_CURVE_POWER  = 3'd1;
  localparam logic [2:0] REG_DUR_PER_SPD  = 3'd2;
  localparam logic [2:0] REG_SPEED_CAP    = 3'd3;
  localparam logic [2:0] REG_MIN_DUR      = 3'd4;
  localparam logic [2:0] REG_MAX_DUR      = 3'd5;
  localparam logic [2:0] REG_VERT_MULT    = 3'd6;
  localparam logic [2:0] REG_NOISE_THR    = 3'd7;

  localparam logic [3:0]  POWER_RESET   = 4'd4;
  localparam logic [23:0] DPS_RESET     = 24'd115200;
  localparam logic [15:0] MIN_DUR_RESET = 16'd30;
  localparam logic [15:0] MAX_DUR_RESET = 16'd1500;
  localparam logic [8:0]  VMULT_RESET   = 9'd256;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SQ,
    ST_CHK,
    ST_SQRT,
    ST_MUL,
    ST_DIVS,
    ST_DIVY,
    ST_FIN,
    ST_ADV,
    ST_OUT
  } top_state_t;

  typedef enum logic [1:0] {
    LN_IDLE,
    LN_DIV,
    LN_POW,
    LN_SCALE
  } lane_state_t;

endpackage

// File: hw/rtl/tic_if.sv
interface tic_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic signed [15:0] vel_x;
  logic signed [15:0] vel_y;
  logic        [31:0] time_ms;
  modport source(output valid, operation, vel_x, vel_y, time_ms, input ready);
  modport sink(input valid, operation, vel_x, vel_y, time_ms, output ready);
endinterface

interface tic_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic               started;
  logic               is_coasting;
  modport source(output valid, out_x, out_y, started, is_coasting, input ready);
  modport sink(input valid, out_x, out_y, started, is_coasting, output ready);
endinterface

// File: hw/rtl/trackball_inertia_coast.sv
// Trackball release inertia.
// in_ch carries one transaction per event: operation 0 starts a coast from the
// release velocity (vel_x, vel_y, signed Q8.8) at time_ms, operation 1 advances
// to time_ms. out_ch returns exactly one transaction per input transaction:
// the decayed velocity, whether a start began coasting, and the coast flag.
// The APB port writes and reads the eight tuning registers at 4*index.
// Items are processed one at a time; the next input is taken in the cycle
// after a result is loaded. A start that coasts runs a digit-by-digit square
// root of FRAC_BITS+8 steps, then a bit-serial divide of FRAC_BITS+40 steps
// for the vertical duration, skipped when the vertical multiplier is zero. A
// dropped start goes to the output after the check in ST_CHK, an advance while
// idle straight after decode. An advance runs both axis lanes side by side,
// each with its own bit-serial divide and power loop; a lane whose axis has
// expired skips both.
// A finished transaction sits in the output register; the next input is taken
// while it waits, and only a second result stalls until out_ch drains.
// Synchronous reset restores register defaults, ends coasting and empties the
// output register.
module trackball_inertia_coast
  import tic_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  tic_in_if.sink            in_ch,
  tic_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int RW = FRAC_BITS + 8;   // speed width
  localparam int PW = FRAC_BITS + 40;  // duration product width, with Y headroom
  localparam int S  = FRAC_BITS + 8;   // duration fraction bits

  // tuning registers
  logic        coast_enable;
  logic [3:0]  curve_power;
  logic [23:0] duration_per_speed;
  logic [15:0] speed_cap;
  logic [15:0] min_duration_ms;
  logic [15:0] max_duration_ms;
  logic [8:0]  vertical_multiplier;
  logic [15:0] noise_threshold;

  // coast state
  logic        coast_active;
  logic [31:0] start_time;
  logic [15:0] duration_x;
  logic [15:0] duration_y;
  logic [3:0]  latched_power;
  logic [15:0] release_x;
  logic [15:0] release_y;

  // captured transaction and working values
  logic        op_l;
  logic [15:0] vx_l;
  logic [15:0] vy_l;
  logic [31:0] t_l;
  logic [31:0] sumsq;
  logic [31:0] nt_sq;
  logic [PW-1:0] prod;

  // pending result and output register
  logic [15:0] res_x;
  logic [15:0] res_y;
  logic        res_started;
  logic        res_coast;
  logic        ovalid;
  logic [15:0] ox;
  logic [15:0] oy;
  logic        ostarted;
  logic        ocoast;

  top_state_t state, state_next;

  logic          wr;
  logic          go_ok;
  logic          sqrt_start;
  logic          sqrt_busy;
  logic [RW-1:0] root;
  logic [RW-1:0] cap;
  logic [RW-1:0] spd;
  logic          divy_start;
  logic          divy_busy;
  logic [PW-1:0] py;
  logic          lane_go;
  logic          busy_x;
  logic          busy_y;
  logic [15:0]   lane_x;
  logic [15:0]   lane_y;
  logic [31:0]   elapsed;
  logic          out_load;
  logic [2*RW-1:0] radicand;

  function automatic logic [15:0] clamp_dur(input logic [PW-1:0] v,
                                            input logic [15:0] lo,
                                            input logic [15:0] hi);
    logic [PW-1:0] lo_s;
    logic [PW-1:0] hi_s;
    logic [PW-1:0] rnd;
    lo_s = PW'(lo) << S;
    hi_s = PW'(hi) << S;
    rnd  = (v + (PW'(1) << (S - 1))) >> S;
    if (v <= lo_s) return lo;
    else if (v >= hi_s) return hi;
    else return rnd[15:0];
  endfunction

  //--------------------------------------------------------------------------
  // APB register file; writes land at the access phase
  //--------------------------------------------------------------------------
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      coast_enable        <= 1'b1;
      curve_power         <= POWER_RESET;
      duration_per_speed  <= DPS_RESET;
      speed_cap           <= '0;
      min_duration_ms     <= MIN_DUR_RESET;
      max_duration_ms     <= MAX_DUR_RESET;
      vertical_multiplier <= VMULT_RESET;
      noise_threshold     <= '0;
    end else if (wr) begin
      case (paddr[4:2])
        REG_COAST_ENABLE: coast_enable        <= pwdata[0];
        REG_CURVE_POWER:  curve_power         <= pwdata[3:0];
        REG_DUR_PER_SPD:  duration_per_speed  <= pwdata[23:0];
        REG_SPEED_CAP:    speed_cap           <= pwdata[15:0];
        REG_MIN_DUR:      min_duration_ms     <= pwdata[15:0];
        REG_MAX_DUR:      max_duration_ms     <= pwdata[15:0];
        REG_VERT_MULT:    vertical_multiplier <= pwdata[8:0];
        REG_NOISE_THR:    noise_threshold     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_COAST_ENABLE: prdata = {31'd0, coast_enable};
      REG_CURVE_POWER:  prdata = {28'd0, curve_power};
      REG_DUR_PER_SPD:  prdata = {8'd0, duration_per_speed};
      REG_SPEED_CAP:    prdata = {16'd0, speed_cap};
      REG_MIN_DUR:      prdata = {16'd0, min_duration_ms};
      REG_MAX_DUR:      prdata = {16'd0, max_duration_ms};
      REG_VERT_MULT:    prdata = {23'd0, vertical_multiplier};
      REG_NOISE_THR:    prdata = {16'd0, noise_threshold};
      default:          prdata = '0;
    endcase
  end

  //--------------------------------------------------------------------------
  // Start path: speed, cap, durations
  //--------------------------------------------------------------------------
  assign go_ok    = coast_enable && (sumsq > nt_sq) && (sumsq != '0);
  // speed keeps FRAC_BITS fraction bits: shift the Q16.16 square up first
  assign radicand = (2*RW)'(sumsq) << (2*FRAC_BITS - 16);
  assign cap      = RW'(speed_cap) << (FRAC_BITS - 8);
  assign spd      = ((speed_cap != '0) && (root > cap)) ? cap : root;

  tic_isqrt #(.RW(RW)) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (radicand),
    .busy     (sqrt_busy),
    .root     (root)
  );

  // Y duration: floor(prod * 256 / vertical_multiplier)
  tic_div #(.NW(PW), .DW(9)) u_divy (
    .clk      (clk),
    .rst      (rst),
    .start    (divy_start),
    .dividend (prod << 8),
    .divisor  (vertical_multiplier),
    .busy     (divy_busy),
    .quotient (py)
  );

  //--------------------------------------------------------------------------
  // Advance path: one lane per axis
  //--------------------------------------------------------------------------
  assign elapsed = t_l - start_time;  // wraps modulo 2^32

  tic_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
    .clk     (clk),
    .rst     (rst),
    .go      (lane_go),
    .elapsed (elapsed),
    .dur     (duration_x),
    .power   (latched_power),
    .rel     (release_x),
    .busy    (busy_x),
    .result  (lane_x)
  );

  tic_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
    .clk     (clk),
    .rst     (rst),
    .go      (lane_go),
    .elapsed (elapsed),
    .dur     (duration_y),
    .power   (latched_power),
    .rel     (release_y),
    .busy    (busy_y),
    .result  (lane_y)
  );

  //--------------------------------------------------------------------------
  // Sequencer
  //--------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_ch.valid) state_next = ST_DECODE;
      ST_DECODE: begin
        if (!op_l) state_next = ST_SQ;
        else if (coast_active) state_next = ST_ADV;
        else state_next = ST_OUT;
      end
      ST_SQ:     state_next = ST_CHK;
      ST_CHK:    state_next = go_ok ? ST_SQRT : ST_OUT;
      ST_SQRT:   if (!sqrt_busy) state_next = ST_MUL;
      ST_MUL:    state_next = ST_DIVS;
      ST_DIVS:   state_next = (vertical_multiplier == '0) ? ST_FIN : ST_DIVY;
      ST_DIVY:   if (!divy_busy) state_next = ST_FIN;
      ST_FIN:    state_next = ST_OUT;
      ST_ADV:    if (!busy_x && !busy_y) state_next = ST_OUT;
      ST_OUT:    if (!ovalid || out_ch.ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = (state == ST_IDLE);
    sqrt_start  = (state == ST_CHK) && go_ok;
    divy_start  = (state == ST_DIVS) && (vertical_multiplier != '0);
    lane_go     = (state == ST_DECODE) && op_l && coast_active;
    out_load    = (state == ST_OUT) && (!ovalid || out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // coast state: a start always clears it first, even when dropped
  always_ff @(posedge clk) begin
    if (rst || (state == ST_DECODE && !op_l)) begin
      coast_active  <= 1'b0;
      start_time    <= '0;
      duration_x    <= '0;
      duration_y    <= '0;
      latched_power <= POWER_RESET;
      release_x     <= '0;
      release_y     <= '0;
    end else if (state == ST_FIN) begin
      coast_active  <= 1'b1;
      start_time    <= t_l;
      duration_x    <= clamp_dur(prod, min_duration_ms, max_duration_ms);
      if (vertical_multiplier == '0) begin
        duration_y <= (min_duration_ms >= max_duration_ms) ? min_duration_ms
                                                           : max_duration_ms;
      end else begin
        duration_y <= clamp_dur(py, min_duration_ms, max_duration_ms);
      end
      latched_power <= curve_power;
      release_x     <= vx_l;
      release_y     <= vy_l;
    end else if (state == ST_ADV && !busy_x && !busy_y) begin
      // stop once both axes have decayed to zero
      coast_active <= (lane_x != '0) || (lane_y != '0);
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      op_l <= in_ch.operation;
      vx_l <= in_ch.vel_x;
      vy_l <= in_ch.vel_y;
      t_l  <= in_ch.time_ms;
    end
    if (state == ST_SQ) begin
      sumsq <= 32'($signed(vx_l) * $signed(vx_l)) + 32'($signed(vy_l) * $signed(vy_l));
      nt_sq <= noise_threshold * noise_threshold;
    end
    if (state == ST_MUL) begin
      prod <= PW'(spd * duration_per_speed);
    end
    case (state)
      ST_DECODE: begin
        res_x       <= '0;
        res_y       <= '0;
        res_started <= 1'b0;
        res_coast   <= 1'b0;
      end
      ST_FIN: begin
        res_started <= 1'b1;
        res_coast   <= 1'b1;
      end
      ST_ADV: begin
        if (!busy_x && !busy_y) begin
          res_x     <= lane_x;
          res_y     <= lane_y;
          res_coast <= (lane_x != '0) || (lane_y != '0);
        end
      end
      default: ;
    endcase
  end

  //--------------------------------------------------------------------------
  // Output register: hold until the sink takes it
  //--------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (out_load) begin
      ovalid <= 1'b1;
    end else if (out_ch.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      ox       <= res_x;
      oy       <= res_y;
      ostarted <= res_started;
      ocoast   <= res_coast;
    end
  end

  assign out_ch.valid       = ovalid;
  assign out_ch.out_x       = ox;
  assign out_ch.out_y       = oy;
  assign out_ch.started     = ostarted;
  assign out_ch.is_coasting = ocoast;

  //--------------------------------------------------------------------------
  // Checks
  //--------------------------------------------------------------------------
  a_adv_needs_coast: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ADV) |-> coast_active)
    else $error("advance running without an active coast");

  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> (state == ST_DECODE))
    else $error("accepted transaction not decoded");

  a_start_coasts: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.started) |-> out_ch.is_coasting)
    else $error("started result without coast flag");

  a_start_zero: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.started) |-> (out_ch.out_x == '0 && out_ch.out_y == '0))
    else $error("start result carries nonzero velocity");

endmodule

// File: hw/rtl/tic_div.sv
module tic_div
  import tic_pkg::*;
#(
  parameter int NW = 32,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic [NW-1:0] quotient
);

  localparam int CW = $clog2(NW + 1);

  logic [CW-1:0] cnt;
  logic [DW-1:0] rem;
  logic [DW:0]   rem_s;
  logic [DW:0]   diff;

  assign rem_s = {rem, quotient[NW-1]};
  assign diff  = rem_s - {1'b0, divisor};
  assign busy  = (cnt != '0);

  // restoring division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(NW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
    end else if (busy) begin
      if (rem_s >= {1'b0, divisor}) begin
        rem      <= diff[DW-1:0];
        quotient <= {quotient[NW-2:0], 1'b1};
      end else begin
        rem      <= rem_s[DW-1:0];
        quotient <= {quotient[NW-2:0], 1'b0};
      end
    end
  end

endmodule

// File: hw/rtl/tic_isqrt.sv
module tic_isqrt
  import tic_pkg::*;
#(
  parameter int RW = 24
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [2*RW-1:0] radicand,
  output logic            busy,
  output logic [RW-1:0]   root
);

  localparam int CW = $clog2(RW + 1);

  logic [CW-1:0]   cnt;
  logic [2*RW-1:0] rad;
  logic [RW:0]     rem;
  logic [RW+2:0]   rem_s;
  logic [RW+2:0]   trial;
  logic [RW+2:0]   diff;

  assign rem_s = {rem, rad[2*RW-1 -: 2]};
  assign trial = {1'b0, root, 2'b01};
  assign diff  = rem_s - trial;
  assign busy  = (cnt != '0);

  // digit-by-digit root, two radicand bits a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(RW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad <= {rad[2*RW-3:0], 2'b00};
      if (rem_s >= trial) begin
        rem  <= diff[RW:0];
        root <= {root[RW-2:0], 1'b1};
      end else begin
        rem  <= rem_s[RW:0];
        root <= {root[RW-2:0], 1'b0};
      end
    end
  end

endmodule

// File: hw/rtl/tic_lane.sv
module tic_lane
  import tic_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [31:0] elapsed,
  input  logic [15:0] dur,
  input  logic [3:0]  power,
  input  logic [15:0] rel,
  output logic        busy,
  output logic [15:0] result
);

  localparam int NW = FRAC_BITS + 16;
  localparam int QW = FRAC_BITS + 1;
  localparam int AW = (QW > 17) ? QW : 17;

  lane_state_t state, state_next;

  logic          expired;
  logic          div_start;
  logic          div_busy;
  logic [NW-1:0] div_q;
  logic [NW-1:0] dividend;
  logic [QW-1:0] r;
  logic [QW-1:0] acc;
  logic [3:0]    cnt;
  logic [16:0]   rel_ext;
  logic [16:0]   mag;
  logic [AW-1:0] mul_a;
  logic [AW-1:0] mul_b;
  logic [2*AW-1:0] prod;
  logic [2*AW-1:0] prod_sh;

  assign expired  = (dur == '0) || (elapsed >= {16'd0, dur});
  assign dividend = NW'(dur - elapsed[15:0]) << FRAC_BITS;
  assign rel_ext  = {rel[15], rel};
  assign mag      = rel[15] ? (17'd0 - rel_ext) : rel_ext;
  assign mul_a    = (state == LN_SCALE) ? AW'(mag) : AW'(acc);
  assign mul_b    = (state == LN_SCALE) ? AW'(acc) : AW'(r);
  assign prod     = mul_a * mul_b;
  assign prod_sh  = prod >> FRAC_BITS;

  tic_div #(.NW(NW), .DW(16)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (dur),
    .busy     (div_busy),
    .quotient (div_q)
  );

  always_comb begin
    state_next = state;
    case (state)
      LN_IDLE:  if (go) state_next = expired ? LN_SCALE : LN_DIV;
      LN_DIV:   if (!div_busy) state_next = LN_POW;
      LN_POW:   if (cnt >= power) state_next = LN_SCALE;
      LN_SCALE: state_next = LN_IDLE;
      default:  state_next = LN_IDLE;
    endcase
  end

  always_comb begin
    div_start = (state == LN_IDLE) && go && !expired;
    busy      = (state != LN_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LN_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      LN_IDLE: begin
        if (go) acc <= '0;
      end
      LN_DIV: begin
        if (!div_busy) begin
          r   <= div_q[QW-1:0];
          acc <= div_q[QW-1:0];
          cnt <= 4'd1;
        end
      end
      LN_POW: begin
        if (cnt < power) begin
          acc <= prod_sh[QW-1:0];
          cnt <= cnt + 4'd1;
        end
      end
      LN_SCALE: begin
        // truncate magnitude, then restore the sign
        result <= rel[15] ? (16'd0 - prod_sh[15:0]) : prod_sh[15:0];
      end
      default: ;
    endcase
  end

endmodule
